### hw/rtl/pat_pkg.sv
`default_nettype none

package pat_pkg;

    localparam int COORD_W    = 32;
    localparam int ANGLE_IN_W = 12;
    localparam int REQ_W      = 3;
    localparam int COEF_FRAC  = 30;
    localparam int MAG_W      = COEF_FRAC + 1;
    localparam int WIDE_W     = 2 * COORD_W + 2;

    // pi/2 in Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD      = 3'd0,
        REQ_ROT_X     = 3'd1,
        REQ_ROT_Y     = 3'd2,
        REQ_ROT_Z     = 3'd3,
        REQ_TRANSLATE = 3'd4,
        REQ_SCALE     = 3'd5
    } t_req;

    typedef struct packed {
        logic                      clip;
        logic signed [COORD_W-1:0] val;
    } t_sat;

    // Clip a wide signed value into the coordinate range.
    function automatic t_sat sat_coord(input logic signed [WIDE_W-1:0] v);
        t_sat r;
        r.clip = 1'b0;
        r.val  = v[COORD_W-1:0];
        if (v > WIDE_W'(COORD_MAX)) begin
            r.clip = 1'b1;
            r.val  = COORD_MAX;
        end else if (v < WIDE_W'(COORD_MIN)) begin
            r.clip = 1'b1;
            r.val  = COORD_MIN;
        end
        return r;
    endfunction

    // Sine of q quarter steps (0..2^qbits) in Q1.30 by a truncated series.
    // Used only to build the constant sine table at elaboration.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned q,
                                                      input int unsigned qbits);
        longint unsigned full;
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        int              k;
        full = 64'd1 << qbits;
        if (q == 0) begin
            return '0;
        end
        if (64'(q) >= full) begin
            return MAG_W'(64'd1 << COEF_FRAC);
        end
        x    = (64'(q) * HALF_PI_Q30) >> qbits;
        term = x;
        sum  = longint'(x);
        for (k = 1; k <= 6; k++) begin
            term = (((term * x) >> COEF_FRAC) * x) >> COEF_FRAC;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << COEF_FRAC)) begin
            sum = longint'(1) << COEF_FRAC;
        end
        return sum[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/point_affine_transform.sv
// An accepted item goes to the stage 1 input register, then to the result register;
//   the sine/cosine table is read as the item enters the input register, and
//   multiply, round and clip feed the result register. The held point is fed back
//   from the result register. Throughput: one item per cycle when not stalled.
// Reset: synchronous, active low; clears both valid flags and sets the point to zero.
`default_nettype none

module point_affine_transform #(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 12
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // input item channel
    input  wire logic                                 i_in_valid,
    output      logic                                 o_in_stall,
    input  wire logic [pat_pkg::REQ_W-1:0]            i_req_type,
    input  wire logic [pat_pkg::ANGLE_IN_W-1:0]       i_angle,
    input  wire logic signed [pat_pkg::COORD_W-1:0]   i_operand_x,
    input  wire logic signed [pat_pkg::COORD_W-1:0]   i_operand_y,
    input  wire logic signed [pat_pkg::COORD_W-1:0]   i_operand_z,
    // result item channel
    output      logic                                 o_out_valid,
    input  wire logic                                 i_out_stall,
    output      logic signed [pat_pkg::COORD_W-1:0]   o_point_x,
    output      logic signed [pat_pkg::COORD_W-1:0]   o_point_y,
    output      logic signed [pat_pkg::COORD_W-1:0]   o_point_z,
    output      logic                                 o_saturated
);

    localparam int CW        = pat_pkg::COORD_W;
    localparam int WW        = pat_pkg::WIDE_W;
    localparam int MW        = pat_pkg::MAG_W;
    localparam int QTR_BITS  = ANGLE_BITS - 2;
    localparam int QTR_FULL  = 1 << QTR_BITS;
    localparam int ROM_DEPTH = QTR_FULL + 1;
    localparam int IDX_W     = QTR_BITS + 1;

    localparam logic signed [WW-1:0] ROT_RND   = WW'(64'd1 << (pat_pkg::COEF_FRAC - 1));
    localparam logic signed [WW-1:0] SCALE_RND = WW'(64'd1 << (FRAC_BITS - 1));

    typedef logic [MW-1:0] t_rom [ROM_DEPTH];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = pat_pkg::quarter_sine(i, QTR_BITS);
        end
        return rom;
    endfunction

    // Quarter-wave sine magnitude, Q1.30, entries 0 .. full quarter inclusive.
    localparam t_rom SINE_ROM = build_rom();

    // ------------------------------------------------------------------
    // Angle folding: pick table index and sign for sine and cosine.
    // cos(a) = sin(a + quarter), so its quadrant is one further on.
    // ------------------------------------------------------------------
    logic [ANGLE_BITS+pat_pkg::ANGLE_IN_W-1:0] ang_ext;
    logic [ANGLE_BITS-1:0]                     ang;
    logic [1:0]                                quad;
    logic [QTR_BITS-1:0]                       ang_rem;
    logic [IDX_W-1:0]                          idx_fwd;
    logic [IDX_W-1:0]                          idx_rev;
    logic [IDX_W-1:0]                          sin_idx;
    logic [IDX_W-1:0]                          cos_idx;

    assign ang_ext = {{ANGLE_BITS{1'b0}}, i_angle};
    assign ang     = ang_ext[ANGLE_BITS-1:0];
    assign quad    = ang[ANGLE_BITS-1 -: 2];
    assign ang_rem = ang[QTR_BITS-1:0];
    assign idx_fwd = {1'b0, ang_rem};
    assign idx_rev = IDX_W'(QTR_FULL) - idx_fwd;
    assign sin_idx = quad[0] ? idx_rev : idx_fwd;
    assign cos_idx = quad[0] ? idx_fwd : idx_rev;

    // ------------------------------------------------------------------
    // Stage 1: registered item plus registered table reads
    // ------------------------------------------------------------------
    logic                   r_s1_valid;
    logic [pat_pkg::REQ_W-1:0] r_s1_req;
    logic signed [CW-1:0]   r_s1_op [3];
    logic [MW-1:0]          r_sin_mag;
    logic [MW-1:0]          r_cos_mag;
    logic                   r_sin_neg;
    logic                   r_cos_neg;

    // Result register; the point it holds is also the block's state.
    logic                   r_out_valid;
    logic signed [CW-1:0]   r_point [3];
    logic                   r_saturated;

    logic out_free;
    logic s1_go;
    logic s1_load;

    // The result slot is free when empty or being taken this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign s1_load    = !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // Load the stage payload and read the table whenever stage 1 moves.
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_req   <= i_req_type;
            r_s1_op[0] <= i_operand_x;
            r_s1_op[1] <= i_operand_y;
            r_s1_op[2] <= i_operand_z;
            r_sin_mag  <= SINE_ROM[sin_idx];
            r_cos_mag  <= SINE_ROM[cos_idx];
            r_sin_neg  <= quad[1];
            r_cos_neg  <= quad[1] ^ quad[0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: multiply, round, clip
    // Each lane forms own*m + other*k. In rotations m is the cosine;
    // in scaling m is the factor and the second product is zero.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] sin_s;
    logic signed [CW-1:0] cos_s;
    logic signed [CW-1:0] sin_neg_s;
    logic                 is_scale;
    logic signed [CW-1:0] mul_b [3];
    logic signed [CW-1:0] oth_a [3];
    logic signed [CW-1:0] oth_b [3];
    logic signed [WW-1:0] rnd;

    assign sin_s     = r_sin_neg ? -CW'({1'b0, r_sin_mag}) : CW'({1'b0, r_sin_mag});
    assign cos_s     = r_cos_neg ? -CW'({1'b0, r_cos_mag}) : CW'({1'b0, r_cos_mag});
    assign sin_neg_s = -sin_s;
    assign is_scale  = (r_s1_req == pat_pkg::REQ_SCALE);
    assign rnd       = is_scale ? SCALE_RND : ROT_RND;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mul_b[i] = is_scale ? r_s1_op[i] : cos_s;
            oth_a[i] = '0;
            oth_b[i] = '0;
        end
        case (r_s1_req)
            pat_pkg::REQ_ROT_X: begin
                oth_a[1] = r_point[2];
                oth_b[1] = sin_neg_s;
                oth_a[2] = r_point[1];
                oth_b[2] = sin_s;
            end
            pat_pkg::REQ_ROT_Y: begin
                oth_a[0] = r_point[2];
                oth_b[0] = sin_s;
                oth_a[2] = r_point[0];
                oth_b[2] = sin_neg_s;
            end
            pat_pkg::REQ_ROT_Z: begin
                oth_a[0] = r_point[1];
                oth_b[0] = sin_neg_s;
                oth_a[1] = r_point[0];
                oth_b[1] = sin_s;
            end
            default: begin
            end
        endcase
    end

    pat_pkg::t_sat mix [3];
    pat_pkg::t_sat trn [3];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic signed [2*CW-1:0] prod_own;
        logic signed [2*CW-1:0] prod_oth;
        logic signed [WW-1:0]   acc;
        logic signed [WW-1:0]   acc_sh;
        logic signed [WW-1:0]   sum_tr;

        assign prod_own = r_point[g] * mul_b[g];
        assign prod_oth = oth_a[g] * oth_b[g];
        assign acc      = WW'(prod_own) + WW'(prod_oth) + rnd;
        assign acc_sh   = is_scale ? (acc >>> FRAC_BITS) : (acc >>> pat_pkg::COEF_FRAC);
        assign mix[g]   = pat_pkg::sat_coord(acc_sh);
        assign sum_tr   = WW'(r_point[g]) + WW'(r_s1_op[g]);
        assign trn[g]   = pat_pkg::sat_coord(sum_tr);
    end

    logic signed [CW-1:0] n_point [3];
    logic                 n_saturated;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_point[i] = r_point[i];
        end
        n_saturated = 1'b0;
        case (r_s1_req)
            pat_pkg::REQ_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    n_point[i] = r_s1_op[i];
                end
            end
            pat_pkg::REQ_ROT_X: begin
                n_point[1]  = mix[1].val;
                n_point[2]  = mix[2].val;
                n_saturated = mix[1].clip | mix[2].clip;
            end
            pat_pkg::REQ_ROT_Y: begin
                n_point[0]  = mix[0].val;
                n_point[2]  = mix[2].val;
                n_saturated = mix[0].clip | mix[2].clip;
            end
            pat_pkg::REQ_ROT_Z: begin
                n_point[0]  = mix[0].val;
                n_point[1]  = mix[1].val;
                n_saturated = mix[0].clip | mix[1].clip;
            end
            pat_pkg::REQ_TRANSLATE: begin
                for (int i = 0; i < 3; i++) begin
                    n_point[i] = trn[i].val;
                end
                n_saturated = trn[0].clip | trn[1].clip | trn[2].clip;
            end
            pat_pkg::REQ_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    n_point[i] = mix[i].val;
                end
                n_saturated = mix[0].clip | mix[1].clip | mix[2].clip;
            end
            default: begin
                // unused codes: hold the point, report it unchanged
            end
        endcase
    end

    // Advance the point only when an item leaves stage 1; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_saturated <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_point[i] <= '0;
            end
        end else begin
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_go) begin
                r_saturated <= n_saturated;
                for (int i = 0; i < 3; i++) begin
                    r_point[i] <= n_point[i];
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_point[0];
    assign o_point_y   = r_point[1];
    assign o_point_z   = r_point[2];
    assign o_saturated = r_saturated;

endmodule

`default_nettype wire

### hw/rtl/pat_checker.sv
`default_nettype none

module pat_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_in_stall,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_stall,
    input wire logic signed [pat_pkg::COORD_W-1:0] o_point_x,
    input wire logic signed [pat_pkg::COORD_W-1:0] o_point_y,
    input wire logic signed [pat_pkg::COORD_W-1:0] o_point_z,
    input wire logic                               o_saturated
);

    // Input backs up only when a finished item waits at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled output item");

    // The point moves only together with a new result item.
    a_point_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (!$stable(o_point_x) || !$stable(o_point_y)
            || !$stable(o_point_z))) |-> o_out_valid)
        else $error("point changed without a result item");

    // A clipped step leaves at least one coordinate at a range limit.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_point_x == pat_pkg::COORD_MAX || o_point_x == pat_pkg::COORD_MIN
             || o_point_y == pat_pkg::COORD_MAX || o_point_y == pat_pkg::COORD_MIN
             || o_point_z == pat_pkg::COORD_MAX || o_point_z == pat_pkg::COORD_MIN))
        else $error("saturation flagged with no coordinate at a limit");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_point_x)
            && $stable(o_point_y) && $stable(o_point_z) && $stable(o_saturated)))
        else $error("stalled result item changed");

endmodule

bind point_affine_transform pat_checker u_pat_checker (.*);

`default_nettype wire
